### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the slot allocator.
// No dependencies; the user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### hdl/mgsa_pkg.sv
// Shared types, constants and helpers of the max-gap slot allocator.
// No dependencies.
package mgsa_pkg;

  localparam int MAX_OCCUPIED = 64;
  localparam int SEAT_BITS    = 16;
  localparam int IDX_W        = $clog2(MAX_OCCUPIED);
  localparam int CNT_W        = $clog2(MAX_OCCUPIED + 1);
  localparam int ROW_W        = SEAT_BITS + 1;
  localparam int CFG_W        = 17;
  localparam int STATUS_W     = 2;

  localparam logic [CFG_W-1:0] SEAT_COUNT_RESET = CFG_W'(16);

  typedef logic [SEAT_BITS-1:0] seat_t;
  typedef logic [ROW_W-1:0]     row_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_UNOCC = 2'd2
  } status_t;

  typedef enum logic {
    REQ_CLAIM   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    seat_t    key;
    logic     found;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic first;
    logic finish;
    logic nonempty;
  } scan_ctrl_t;

  // Clamp the configured seat count into 1 .. 2^SEAT_BITS.
  function automatic row_t row_len(input logic [CFG_W-1:0] cnt);
    logic [CFG_W:0] top;
    top = (CFG_W+1)'(1) << SEAT_BITS;
    if (cnt == '0) begin
      return ROW_W'(1);
    end else if ({1'b0, cnt} > top) begin
      return ROW_W'(top);
    end else begin
      return ROW_W'(cnt);
    end
  endfunction

endpackage

### hdl/mgsa_cell.sv
// One cell of the occupied-slot chain: holds one table entry.
// Depends on mgsa_pkg.
module mgsa_cell
  import mgsa_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid_i,
  input  logic       left_keep_i,
  input  seat_t      left_val_i,
  input  seat_t      right_val_i,
  output seat_t      val_o,
  output logic       keep_o,
  output logic       match_o
);

  seat_t val_r;
  seat_t val_nxt;
  logic  lt;

  assign lt      = val_r < ctrl.key;
  assign keep_o  = valid_i && lt;
  assign match_o = valid_i && (val_r == ctrl.key);
  assign val_o   = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CELL_ROTATE: val_nxt = right_val_i;
      CELL_INSERT: begin
        // the first cell not below the new key takes it, the rest move right
        if (!keep_o) begin
          val_nxt = left_keep_i ? ctrl.key : left_val_i;
        end
      end
      CELL_REMOVE: begin
        if (ctrl.found && valid_i && !lt) begin
          val_nxt = right_val_i;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hdl/mgsa_scan.sv
// Gap tracker: walks the table entries one per cycle and keeps the widest gap.
// Depends on mgsa_pkg.
module mgsa_scan
  import mgsa_pkg::*;
(
  input  logic       clk,
  input  scan_ctrl_t ctl,
  input  seat_t      head_i,
  input  row_t       row_len_i,
  output seat_t      pick_o,
  output logic       none_o
);

  row_t  start_r, start_nxt;
  row_t  best_r, best_nxt;
  seat_t pick_r, pick_nxt;
  logic  none_r, none_nxt;

  row_t             gap;
  row_t             half;
  row_t             mid;
  logic [ROW_W:0]   end_gap;

  assign gap     = {1'b0, head_i} + ROW_W'(1) - start_r;
  assign half    = gap >> 1;
  assign mid     = start_r + half - ROW_W'(1);
  assign end_gap = {1'b0, row_len_i} - {1'b0, start_r};

  always_comb begin
    start_nxt = start_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    none_nxt  = none_r;
    if (ctl.clear) begin
      start_nxt = '0;
      best_nxt  = '0;
      pick_nxt  = '0;
    end else if (ctl.step) begin
      if (ctl.first) begin
        if ({1'b0, head_i} > best_r) begin
          best_nxt = {1'b0, head_i};
          pick_nxt = '0;
        end
      end else if (half > best_r) begin
        best_nxt = half;
        pick_nxt = mid[SEAT_BITS-1:0];
      end
      start_nxt = {1'b0, head_i} + ROW_W'(1);
    end else if (ctl.finish) begin
      // end gap counts only when positive
      if (ctl.nonempty && !end_gap[ROW_W] && (end_gap[ROW_W-1:0] > best_r)) begin
        best_nxt = end_gap[ROW_W-1:0];
        pick_nxt = SEAT_BITS'(row_len_i - ROW_W'(1));
      end
      none_nxt = ctl.nonempty && (best_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    none_r  <= none_nxt;
  end

  assign pick_o = pick_r;
  assign none_o = none_r;

endmodule

### hdl/max_gap_slot_allocator_unit.sv
// Top level of the max-gap slot allocator: control, cell chain and gap tracker.
// Depends on mgsa_pkg, mgsa_cell, mgsa_scan and assert_macros.svh.
//
//  port group | dir | beat contents
//  in_*       | in  | tdata: seat_number[15:0]; tuser: req_type
//  out_*      | out | tdata: chosen_seat[15:0]; tuser: status[1:0]
//  cfg_*      | in  | seat_count[16:0], written when cfg_we is high
//
// A claim runs ST_SCAN, rotating the chain once through all 64 cells past the gap
// tracker, ST_FINISH to close the end gap, ST_INSERT to insert and ST_DONE to load the
// output register; a release runs ST_FIND, ST_REMOVE and ST_DONE, a claim on a full
// table only ST_DONE. One item is in work at a time; in_tready is high while idle, even
// if a result still waits, and completion holds until the output register frees.
// rst_n clears the count, control state and seat_count (to 16).
`include "assert_macros.svh"

module max_gap_slot_allocator_unit
  import mgsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // seat_number[15:0]
  input  logic                 in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // chosen_seat[15:0]
  output logic [1:0]           out_tuser,  // status[1:0]
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_FINISH = 7'b0000100,
    ST_INSERT = 7'b0001000,
    ST_FIND   = 7'b0010000,
    ST_REMOVE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] seat_count_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  seat_t            slot_r, slot_nxt;
  logic             found_r, found_nxt;
  seat_t            res_seat_r, res_seat_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  seat_t            out_seat_r, out_seat_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             in_fire;
  logic             out_free;
  row_t             row_n;
  cell_ctrl_t       cctl;
  scan_ctrl_t       sctl;
  seat_t            pick;
  logic             none;

  seat_t                   vals  [MAX_OCCUPIED];
  logic [MAX_OCCUPIED-1:0] keeps;
  logic [MAX_OCCUPIED-1:0] hit_bits;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign row_n     = row_len(seat_count_r);

  // cell chain: rotate toward cell 0, shift right on insert, left on remove
  for (genvar i = 0; i < MAX_OCCUPIED; i++) begin : g_cell
    localparam int R = (i + 1) % MAX_OCCUPIED;
    localparam int L = (i + MAX_OCCUPIED - 1) % MAX_OCCUPIED;
    mgsa_cell u_cell (
      .clk         (clk),
      .ctrl        (cctl),
      .valid_i     (CNT_W'(i) < count_r),
      .left_keep_i ((i == 0) ? 1'b1 : keeps[L]),
      .left_val_i  (vals[L]),
      .right_val_i (vals[R]),
      .val_o       (vals[i]),
      .keep_o      (keeps[i]),
      .match_o     (hit_bits[i])
    );
  end

  mgsa_scan u_scan (
    .clk       (clk),
    .ctl       (sctl),
    .head_i    (vals[0]),
    .row_len_i (row_n),
    .pick_o    (pick),
    .none_o    (none)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    res_seat_nxt   = res_seat_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_seat_nxt   = out_seat_r;
    out_status_nxt = out_status_r;

    cctl.op    = CELL_HOLD;
    cctl.key   = slot_r;
    cctl.found = found_r;

    sctl.clear    = 1'b0;
    sctl.step     = 1'b0;
    sctl.first    = (step_r == '0);
    sctl.finish   = 1'b0;
    sctl.nonempty = (count_r != '0);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          slot_nxt     = in_tdata;
          res_seat_nxt = '0;
          step_nxt     = '0;
          if (req_t'(in_tuser) == REQ_RELEASE) begin
            state_nxt = ST_FIND;
          end else if (count_r == CNT_W'(MAX_OCCUPIED)) begin
            res_status_nxt = STAT_FULL;
            state_nxt      = ST_DONE;
          end else begin
            sctl.clear = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cctl.op   = CELL_ROTATE;
        sctl.step = ({1'b0, step_r} < count_r);
        step_nxt  = step_r + IDX_W'(1);
        if (step_r == IDX_W'(MAX_OCCUPIED - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        sctl.finish = 1'b1;
        state_nxt   = ST_INSERT;
      end
      ST_INSERT: begin
        cctl.key = pick;
        if (none) begin
          res_status_nxt = STAT_FULL;
        end else begin
          cctl.op        = CELL_INSERT;
          count_nxt      = count_r + CNT_W'(1);
          res_seat_nxt   = pick;
          res_status_nxt = STAT_OK;
        end
        state_nxt = ST_DONE;
      end
      ST_FIND: begin
        found_nxt = |hit_bits;
        state_nxt = ST_REMOVE;
      end
      ST_REMOVE: begin
        if (found_r) begin
          cctl.op        = CELL_REMOVE;
          count_nxt      = count_r - CNT_W'(1);
          res_status_nxt = STAT_OK;
        end else begin
          res_status_nxt = STAT_UNOCC;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_seat_nxt   = res_seat_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      seat_count_r <= SEAT_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seat_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    slot_r       <= slot_nxt;
    found_r      <= found_nxt;
    res_seat_r   <= res_seat_nxt;
    res_status_r <= res_status_nxt;
    out_seat_r   <= out_seat_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_seat_r;
  assign out_tuser  = out_status_r;

  `ASSERT_NEVER(a_count_bound, count_r > CNT_W'(MAX_OCCUPIED), "occupied count overflow")
  `ASSERT_CLK(a_insert_room, (state_r == ST_INSERT) |-> (count_r < CNT_W'(MAX_OCCUPIED)), "insert into full table")
  `ASSERT_CLK(a_full_claim, (in_fire && !in_tuser && count_r == CNT_W'(MAX_OCCUPIED)) |=> (state_r == ST_DONE && res_status_r == STAT_FULL), "claim on full table not flagged")
  `ASSERT_CLK(a_miss_keeps, (state_r == ST_REMOVE && !found_r) |=> $stable(count_r), "unoccupied release changed count")
  `ASSERT_CLK(a_done_only, (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_DONE), "result loaded outside completion")

endmodule
